FILE: src/fcl_pkg.sv
// ----------------------------------------------------------------------------
// FAT cluster chain lookup package
// Shared widths, codes, word types and the decode constants of the lookup.
// ----------------------------------------------------------------------------
package fcl_pkg;

  localparam int SECTOR_BYTES  = 512;
  localparam int CACHE_SECTORS = 2;
  localparam int WINDOW_BYTES  = SECTOR_BYTES * CACHE_SECTORS;
  localparam int SECTOR_SHIFT  = $clog2(SECTOR_BYTES);

  localparam int LANES     = 4;
  localparam int LANE_W    = $clog2(LANES);
  localparam int BANK_ROWS = WINDOW_BYTES / LANES;
  localparam int ROW_W     = $clog2(BANK_ROWS);

  localparam int CLUSTER_W  = 28;
  localparam int OFFSET_W   = CLUSTER_W + 2;
  localparam int SECTOR_W   = 21;
  localparam int LBA_W      = 22;
  localparam int FOFF_W     = 10;
  localparam int RESERVED_W = 16;
  localparam int KIND_W     = 2;
  localparam int ADDR_W     = (SECTOR_W + SECTOR_SHIFT > OFFSET_W) ?
                              SECTOR_W + SECTOR_SHIFT : OFFSET_W;
  localparam int LEN_W      = 3;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_FAT_KIND = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED = 1'b1;

  localparam logic [KIND_W-1:0] KIND_FAT12 = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FAT16 = 2'd1;

  localparam logic [LEN_W-1:0] LEN_SHORT = 3'd2;
  localparam logic [LEN_W-1:0] LEN_LONG  = 3'd4;

  localparam logic [11:0] FAT12_MASK = 12'hFFF;
  localparam logic [11:0] FAT12_EOC  = 12'hFF8;
  localparam logic [31:0] FAT12_EXT  = 32'hFFFF_F000;
  localparam logic [15:0] FAT16_EOC  = 16'hFFF8;
  localparam logic [31:0] FAT16_EXT  = 32'hFFFF_0000;
  localparam logic [31:0] FAT32_MASK = 32'h0FFF_FFFF;
  localparam logic [31:0] FAT32_EOC  = 32'h0FFF_FFF8;
  localparam logic [31:0] FAT32_EXT  = 32'hF000_0000;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_FILL   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_HIT  = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FILL = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [CLUSTER_W-1:0]  cluster;
    logic [SECTOR_W-1:0]   fill_window_sector;
    logic [FOFF_W-1:0]     fill_offset;
    logic [7:0]            fill_byte;
    logic                  fill_last;
  } request_t;

  typedef struct packed {
    status_t               status;
    logic [31:0]           next_cluster;
    logic                  end_of_chain;
    logic [SECTOR_W-1:0]   refill_sector;
    logic [LBA_W-1:0]      refill_lba;
  } result_t;

  typedef struct packed {
    logic                  fill;
    logic                  hit;
    logic [KIND_W-1:0]     kind;
    logic                  odd;
    logic [LANE_W-1:0]     lane;
    logic [SECTOR_W-1:0]   sector;
    logic [LBA_W-1:0]      lba;
  } loc_t;

  typedef struct packed {
    logic                         we;
    logic [LANE_W-1:0]            wlane;
    logic [ROW_W-1:0]             wrow;
    logic [7:0]                   wdata;
    logic [LANES-1:0][ROW_W-1:0]  rrow;
  } cache_req_t;

endpackage

FILE: src/fcl_locate.sv
// ----------------------------------------------------------------------------
// FAT entry locator
// Works out the entry offset, sector and window hit, and the cache bank
// accesses for one word.
// ----------------------------------------------------------------------------
module fcl_locate (
  input  logic                            valid,
  input  fcl_pkg::request_t               request,
  input  logic [fcl_pkg::KIND_W-1:0]      fat_kind,
  input  logic [fcl_pkg::RESERVED_W-1:0]  reserved_sectors,
  input  logic                            win_valid,
  input  logic [fcl_pkg::SECTOR_W-1:0]    win_sector,
  output fcl_pkg::loc_t                   loc,
  output fcl_pkg::cache_req_t             cache_req
);

  logic [fcl_pkg::OFFSET_W-1:0] triple;
  logic [fcl_pkg::OFFSET_W-1:0] offset;
  logic [fcl_pkg::LEN_W-1:0]    entry_len;
  logic [fcl_pkg::ADDR_W-1:0]   offset_w;
  logic [fcl_pkg::ADDR_W-1:0]   win_lo;
  logic [fcl_pkg::ADDR_W-1:0]   rel;
  logic [fcl_pkg::ADDR_W:0]     rel_end;
  logic [fcl_pkg::ROW_W-1:0]    row;
  logic [fcl_pkg::SECTOR_W-1:0] sector;

  assign triple = (fcl_pkg::OFFSET_W'(request.cluster) << 1) +
                  fcl_pkg::OFFSET_W'(request.cluster);

  always_comb begin
    if (fat_kind == fcl_pkg::KIND_FAT12) begin
      offset    = triple >> 1;
      entry_len = fcl_pkg::LEN_SHORT;
    end else if (fat_kind == fcl_pkg::KIND_FAT16) begin
      offset    = fcl_pkg::OFFSET_W'(request.cluster) << 1;
      entry_len = fcl_pkg::LEN_SHORT;
    end else begin
      offset    = fcl_pkg::OFFSET_W'(request.cluster) << 2;
      entry_len = fcl_pkg::LEN_LONG;
    end
  end

  assign offset_w = fcl_pkg::ADDR_W'(offset);
  assign win_lo   = fcl_pkg::ADDR_W'(win_sector) << fcl_pkg::SECTOR_SHIFT;
  assign rel      = offset_w - win_lo;
  assign rel_end  = {1'b0, rel} + (fcl_pkg::ADDR_W + 1)'(entry_len);
  assign sector   = fcl_pkg::SECTOR_W'(offset_w >> fcl_pkg::SECTOR_SHIFT);
  assign row      = fcl_pkg::ROW_W'(rel >> fcl_pkg::LANE_W);

  always_comb begin
    loc.fill   = (request.cmd == fcl_pkg::CMD_FILL);
    loc.hit    = win_valid && (offset_w >= win_lo) &&
                 (rel_end <= (fcl_pkg::ADDR_W + 1)'(fcl_pkg::WINDOW_BYTES));
    loc.kind   = fat_kind;
    loc.odd    = request.cluster[0];
    loc.lane   = rel[fcl_pkg::LANE_W-1:0];
    loc.sector = sector;
    loc.lba    = fcl_pkg::LBA_W'(reserved_sectors) + fcl_pkg::LBA_W'(sector);
  end

  always_comb begin
    cache_req.we    = valid && (request.cmd == fcl_pkg::CMD_FILL) &&
                      (32'(request.fill_offset) < 32'(fcl_pkg::WINDOW_BYTES));
    cache_req.wlane = request.fill_offset[fcl_pkg::LANE_W-1:0];
    cache_req.wrow  = fcl_pkg::ROW_W'(request.fill_offset >> fcl_pkg::LANE_W);
    cache_req.wdata = request.fill_byte;
    for (int b = 0; b < fcl_pkg::LANES; b++) begin
      cache_req.rrow[b] = row + fcl_pkg::ROW_W'(fcl_pkg::LANE_W'(b) < rel[fcl_pkg::LANE_W-1:0]);
    end
  end

endmodule

FILE: src/fcl_cache.sv
// ----------------------------------------------------------------------------
// FAT window cache
// Four byte banks interleaved on the low address bits; one word of four
// consecutive bytes is read per cycle with registered read data.
// ----------------------------------------------------------------------------
module fcl_cache (
  input  logic                              clk,
  input  fcl_pkg::cache_req_t               cache_req,
  output logic [fcl_pkg::LANES-1:0][7:0]    rdata
);

  for (genvar b = 0; b < fcl_pkg::LANES; b++) begin : g_bank
    logic [7:0] mem [fcl_pkg::BANK_ROWS];
    logic [7:0] q;

    always_ff @(posedge clk) begin
      if (cache_req.we && (cache_req.wlane == fcl_pkg::LANE_W'(b))) begin
        mem[cache_req.wrow] <= cache_req.wdata;
      end
      q <= mem[cache_req.rrow[b]];
    end

    assign rdata[b] = q;
  end

endmodule

FILE: src/fcl_decode.sv
// ----------------------------------------------------------------------------
// FAT entry decoder
// Aligns the bank bytes and decodes the FAT12, FAT16 or FAT32 entry into
// the result word.
// ----------------------------------------------------------------------------
module fcl_decode (
  input  fcl_pkg::loc_t                     loc,
  input  logic [fcl_pkg::LANES-1:0][7:0]    rdata,
  output fcl_pkg::result_t                  result
);

  logic [fcl_pkg::LANES-1:0][7:0] bytes;
  logic [15:0]                    w16;
  logic [11:0]                    v12;
  logic [31:0]                    v32;
  logic [31:0]                    value;
  logic                           eoc;

  always_comb begin
    for (int k = 0; k < fcl_pkg::LANES; k++) begin
      bytes[k] = rdata[fcl_pkg::LANE_W'(k) + loc.lane];
    end
  end

  assign w16 = {bytes[1], bytes[0]};
  assign v12 = loc.odd ? w16[15:4] : (w16[11:0] & fcl_pkg::FAT12_MASK);
  assign v32 = bytes & fcl_pkg::FAT32_MASK;

  always_comb begin
    if (loc.kind == fcl_pkg::KIND_FAT12) begin
      eoc   = (v12 >= fcl_pkg::FAT12_EOC);
      value = eoc ? (32'(v12) | fcl_pkg::FAT12_EXT) : 32'(v12);
    end else if (loc.kind == fcl_pkg::KIND_FAT16) begin
      eoc   = (w16 >= fcl_pkg::FAT16_EOC);
      value = eoc ? (32'(w16) | fcl_pkg::FAT16_EXT) : 32'(w16);
    end else begin
      eoc   = (v32 >= fcl_pkg::FAT32_EOC);
      value = eoc ? (v32 | fcl_pkg::FAT32_EXT) : v32;
    end
  end

  always_comb begin
    result = '0;
    if (loc.fill) begin
      result.status = fcl_pkg::STATUS_FILL;
    end else if (loc.hit) begin
      result.status       = fcl_pkg::STATUS_HIT;
      result.next_cluster = value;
      result.end_of_chain = eoc;
    end else begin
      result.status        = fcl_pkg::STATUS_MISS;
      result.refill_sector = loc.sector;
      result.refill_lba    = loc.lba;
    end
  end

endmodule

FILE: src/fat_cluster_chain_lookup_core.sv
// ----------------------------------------------------------------------------
// FAT cluster chain lookup core
// Next-cluster lookup through a cached window of FAT sectors.
// ----------------------------------------------------------------------------
// A request word is taken at a rising edge with start high and busy low.
// A lookup word carries a cluster; a fill word writes one byte of the
// window cache, and its last byte makes the window valid at the given
// sector. Each word gives exactly one result word, shown on result for a
// single cycle with done high; the receiver cannot hold it off.
// A word passes the input register, locate plus cache bank read, and
// decode into the result register before done is raised. Throughput:
// one word every cycle while busy is low, set by the single read of the
// four cache banks per cycle; a fill is visible to the next lookup.
// Configuration goes through cfg_valid/cfg_ready (always ready): index 0
// is fat_kind, index 1 is reserved_sectors; write only while idle.
// Reset clears the pipeline, sets fat_kind to FAT12, reserved_sectors to
// one and invalidates the window, so every lookup misses until a last fill byte.
// busy is high for one cycle after reset and low from then on.
// ----------------------------------------------------------------------------
module fat_cluster_chain_lookup_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  fcl_pkg::request_t                 request,
  output logic                              done,
  output fcl_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fcl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                             in_valid;
  fcl_pkg::request_t                in_q;
  logic [fcl_pkg::KIND_W-1:0]       fat_kind;
  logic [fcl_pkg::RESERVED_W-1:0]   reserved_sectors;
  logic                             win_valid;
  logic [fcl_pkg::SECTOR_W-1:0]     win_sector;
  logic                             loc_valid;
  fcl_pkg::loc_t                    loc_q;
  fcl_pkg::loc_t                    loc_next;
  fcl_pkg::cache_req_t              cache_req;
  logic [fcl_pkg::LANES-1:0][7:0]   rdata;
  fcl_pkg::result_t                 result_next;
  logic                             win_load;

  assign cfg_ready = 1'b1;
  assign win_load  = in_valid && (in_q.cmd == fcl_pkg::CMD_FILL) && in_q.fill_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_kind         <= fcl_pkg::KIND_FAT12;
      reserved_sectors <= fcl_pkg::RESERVED_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fcl_pkg::CFG_FAT_KIND: fat_kind         <= cfg_data[fcl_pkg::KIND_W-1:0];
        fcl_pkg::CFG_RESERVED: reserved_sectors <= cfg_data[fcl_pkg::RESERVED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_q <= request;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (win_load) begin
      win_valid <= 1'b1;
    end
    if (win_load) begin
      win_sector <= in_q.fill_window_sector;
    end
  end

  fcl_locate u_locate (
    .valid            (in_valid),
    .request          (in_q),
    .fat_kind         (fat_kind),
    .reserved_sectors (reserved_sectors),
    .win_valid        (win_valid),
    .win_sector       (win_sector),
    .loc              (loc_next),
    .cache_req        (cache_req)
  );

  fcl_cache u_cache (
    .clk       (clk),
    .cache_req (cache_req),
    .rdata     (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      loc_valid <= 1'b0;
    end else begin
      loc_valid <= in_valid;
    end
    loc_q <= loc_next;
  end

  fcl_decode u_decode (
    .loc    (loc_q),
    .rdata  (rdata),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= loc_valid;
    end
    result <= result_next;
  end

endmodule

FILE: dv/fcl_chain_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT cluster chain lookup checker
// Watches the request, result and configuration channels of the lookup core.
// Keeps its own copy of the FAT type, reserved sectors, cached window and
// cache bytes, works out the result word for every accepted request word and
// compares each result word, field by field, with the oldest one predicted.
// ----------------------------------------------------------------------------
module fcl_chain_checker
  import fcl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  request_t               request,
  input  logic                   done,
  input  result_t                result,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     failures,
  output int                     pending,
  output int                     hit_count,
  output int                     miss_count,
  output int                     fill_count,
  output int                     eoc_count
);

  logic [KIND_W-1:0]     kind_q;
  logic [RESERVED_W-1:0] reserved_q;
  logic [31:0]           win_base;
  logic [7:0]            cache_mem [WINDOW_BYTES];
  result_t               expected_links [$];

  assign pending = expected_links.size();

  function automatic logic [31:0] cache_at(input logic [63:0] idx);
    return (idx < WINDOW_BYTES) ? {24'd0, cache_mem[idx[FOFF_W-1:0]]} : 32'd0;
  endfunction

  function automatic result_t decode_link(input request_t rq);
    logic [63:0] off;
    logic [63:0] lo;
    logic [63:0] sect;
    logic [63:0] lba;
    logic [31:0] w;
    logic [31:0] val;
    int          len;
    result_t     res;
    res = '0;
    if (rq.cmd == CMD_FILL) begin
      cache_mem[rq.fill_offset] = rq.fill_byte;
      if (rq.fill_last)
        win_base = {11'd0, rq.fill_window_sector};
      res.status = STATUS_FILL;
      fill_count++;
      return res;
    end
    case (kind_q)
      KIND_FAT12: begin
        off = ({36'd0, rq.cluster} * 64'd3) >> 1;
        len = 2;
      end
      KIND_FAT16: begin
        off = {36'd0, rq.cluster} << 1;
        len = 2;
      end
      default: begin
        off = {36'd0, rq.cluster} << 2;
        len = 4;
      end
    endcase
    lo = {32'd0, win_base} << SECTOR_SHIFT;
    if (off < lo || off + 64'(len) > lo + 64'(WINDOW_BYTES)) begin
      sect = off >> SECTOR_SHIFT;
      lba  = {48'd0, reserved_q} + sect;
      res.status        = STATUS_MISS;
      res.refill_sector = sect[SECTOR_W-1:0];
      res.refill_lba    = lba[LBA_W-1:0];
      miss_count++;
      return res;
    end
    off = off - lo;
    w = cache_at(off) | (cache_at(off + 1) << 8) | (cache_at(off + 2) << 16) |
        (cache_at(off + 3) << 24);
    case (kind_q)
      KIND_FAT12: begin
        val = rq.cluster[0] ? {20'd0, w[15:4]} : {20'd0, w[11:0]};
        res.end_of_chain = (val[11:0] >= FAT12_EOC);
        if (res.end_of_chain)
          val = val | FAT12_EXT;
      end
      KIND_FAT16: begin
        val = {16'd0, w[15:0]};
        res.end_of_chain = (val[15:0] >= FAT16_EOC);
        if (res.end_of_chain)
          val = val | FAT16_EXT;
      end
      default: begin
        val = w & FAT32_MASK;
        res.end_of_chain = (val >= FAT32_EOC);
        if (res.end_of_chain)
          val = val | FAT32_EXT;
      end
    endcase
    res.status       = STATUS_HIT;
    res.next_cluster = val;
    hit_count++;
    if (res.end_of_chain)
      eoc_count++;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      kind_q     = KIND_FAT12;
      reserved_q = 16'd1;
      win_base   = '1;
      for (int i = 0; i < WINDOW_BYTES; i++)
        cache_mem[i] = 8'd0;
      expected_links.delete();
    end else begin
      if (done) begin
        if (expected_links.size() == 0) begin
          $error("result word with none expected");
          failures++;
        end else begin
          want = expected_links.pop_front();
          check_field("status", 32'(want.status), 32'(result.status));
          check_field("next_cluster", want.next_cluster, result.next_cluster);
          check_field("end_of_chain", 32'(want.end_of_chain), 32'(result.end_of_chain));
          check_field("refill_sector", 32'(want.refill_sector), 32'(result.refill_sector));
          check_field("refill_lba", 32'(want.refill_lba), 32'(result.refill_lba));
        end
      end
      if (start && !busy)
        expected_links.push_back(decode_link(request));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FAT_KIND: kind_q = cfg_data[KIND_W-1:0];
          CFG_RESERVED: reserved_q = cfg_data[RESERVED_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT cluster chain lookup testbench
// Drives lookup and fill words into the core: a short directed run over the
// decode thresholds, odd and even FAT12 entries, a straddling entry and the
// largest sectors, then random host sessions per FAT type and reserved-sector
// setting (miss, window refill, lookups into it) mixed with noise words.
// The checker beside the core predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module testbench;
  import fcl_pkg::*;

  localparam logic [KIND_W-1:0] KIND_FAT32 = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int DIRECTED    = 25;
  localparam int PER_PHASE   = 175;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  request_t               request = '0;
  logic                   done;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int failures, pending, hit_count, miss_count, fill_count, eoc_count;
  int sent = 0;
  int stall_cycles = 0;
  bit burst = 1'b0;

  logic [KIND_W-1:0] kind_sel = KIND_FAT12;
  logic [31:0]       win_sec = '1;
  bit                byte_seen [WINDOW_BYTES];

  always #5 clk = ~clk;

  fat_cluster_chain_lookup_core u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fcl_chain_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .failures   (failures),
    .pending    (pending),
    .hit_count  (hit_count),
    .miss_count (miss_count),
    .fill_count (fill_count),
    .eoc_count  (eoc_count)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic request_t any_request();
    request_t rq;
    rq.cmd                = CMD_LOOKUP;
    rq.cluster            = CLUSTER_W'($urandom);
    rq.fill_window_sector = SECTOR_W'($urandom);
    rq.fill_offset        = FOFF_W'($urandom);
    rq.fill_byte          = 8'($urandom);
    rq.fill_last          = 1'($urandom);
    return rq;
  endfunction

  function automatic logic [7:0] pick_byte(input int mode);
    if (mode < 20)
      return 8'hFF;
    else if (mode < 35)
      return 8'hF0 | 8'($urandom_range(0, 15));
    else
      return 8'($urandom);
  endfunction

  // where the entry of cluster c sits in the cached window, if it sits there
  function automatic bit window_hit(input logic [CLUSTER_W-1:0] c, output int idx,
                                    output int len);
    logic [63:0] off;
    logic [63:0] lo;
    case (kind_sel)
      KIND_FAT12: begin
        off = ({36'd0, c} * 64'd3) >> 1;
        len = 2;
      end
      KIND_FAT16: begin
        off = {36'd0, c} << 1;
        len = 2;
      end
      default: begin
        off = {36'd0, c} << 2;
        len = 4;
      end
    endcase
    lo  = {32'd0, win_sec} << SECTOR_SHIFT;
    idx = int'(off - lo);
    return (off >= lo) && (off + 64'(len) <= lo + 64'(WINDOW_BYTES));
  endfunction

  task automatic send(input request_t rq);
    int gap;
    int r;
    gap = 0;
    if (!burst) begin
      r = $urandom_range(0, 99);
      if (r >= 60)
        gap = (r < 90) ? $urandom_range(1, 3) :
              (r < 98) ? $urandom_range(4, 10) : $urandom_range(20, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic put_byte(input logic [FOFF_W-1:0] off, input logic [7:0] val,
                          input bit last, input logic [SECTOR_W-1:0] sect);
    request_t rq;
    rq = any_request();
    rq.cmd                = CMD_FILL;
    rq.fill_offset        = off;
    rq.fill_byte          = val;
    rq.fill_last          = last;
    rq.fill_window_sector = sect;
    send(rq);
    byte_seen[off] = 1'b1;
    if (last)
      win_sec = {11'd0, sect};
  endtask

  // write any unwritten byte a hit would read, then look up
  task automatic look_up(input logic [CLUSTER_W-1:0] c);
    int idx;
    int len;
    int mode;
    request_t rq;
    mode = $urandom_range(0, 99);
    if (window_hit(c, idx, len))
      for (int i = 0; i < len; i++)
        if (!byte_seen[idx + i])
          put_byte(FOFF_W'(idx + i), pick_byte(mode), 1'b0, SECTOR_W'($urandom));
    rq = any_request();
    rq.cmd     = CMD_LOOKUP;
    rq.cluster = c;
    send(rq);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_FAT_KIND)
      kind_sel = val[KIND_W-1:0];
  endtask

  // one host session: miss, refill part of a window, then chase entries in it
  task automatic session();
    longint ws_max;
    longint ws;
    longint base;
    longint span;
    int     n;
    int     r;
    burst = ($urandom_range(0, 3) == 0);
    case (kind_sel)
      KIND_FAT12: ws_max = 786430;
      KIND_FAT16: ws_max = 1048574;
      default:    ws_max = 2097150;
    endcase
    ws = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 31) : $urandom_range(0, ws_max);
    case (kind_sel)
      KIND_FAT12: begin
        base = (ws * 1024 + 2) / 3;
        span = 683;
      end
      KIND_FAT16: begin
        base = ws * 256;
        span = 512;
      end
      default: begin
        base = ws * 128;
        span = 256;
      end
    endcase
    look_up(CLUSTER_W'(base + $urandom_range(0, span)));
    n = $urandom_range(1, 8);
    for (int i = 1; i < n; i++)
      put_byte(FOFF_W'($urandom), pick_byte($urandom_range(0, 99)), 1'b0, SECTOR_W'($urandom));
    put_byte(FOFF_W'($urandom), pick_byte($urandom_range(0, 99)), 1'b1,
             ($urandom_range(0, 9) == 0) ? SECTOR_W'($urandom) : SECTOR_W'(ws));
    n = $urandom_range(4, 14);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        look_up(CLUSTER_W'(base - 1 + $urandom_range(0, span + 1)));
      else if (r < 90)
        look_up(CLUSTER_W'($urandom));
      else
        put_byte(FOFF_W'($urandom), 8'($urandom), ($urandom_range(0, 15) == 0),
                 SECTOR_W'($urandom));
    end
  endtask

  initial begin
    logic [KIND_W-1:0]     kind_p;
    logic [RESERVED_W-1:0] res_p;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    look_up(28'd0);
    look_up(28'hFFF_FFFF);
    put_byte(10'd0, 8'hF7, 1'b0, 21'd0);
    put_byte(10'd1, 8'h8F, 1'b0, 21'd0);
    put_byte(10'd2, 8'hFF, 1'b0, 21'd0);
    put_byte(10'd3, 8'h0F, 1'b1, 21'd0);
    look_up(28'd0);
    look_up(28'd1);
    look_up(28'd682);
    set_reg(CFG_FAT_KIND, 16'(KIND_FAT16));
    look_up(28'd0);
    look_up(28'd1);
    put_byte(10'd4, 8'hF8, 1'b0, 21'd0);
    put_byte(10'd5, 8'hFF, 1'b0, 21'd0);
    put_byte(10'd6, 8'hFF, 1'b0, 21'd0);
    put_byte(10'd7, 8'hFF, 1'b0, 21'd0);
    look_up(28'd2);
    set_reg(CFG_FAT_KIND, 16'(KIND_FAT32));
    look_up(28'd0);
    look_up(28'd1);
    set_reg(CFG_FAT_KIND, 16'(KIND_SPARE));
    set_reg(CFG_RESERVED, 16'hFFFF);
    look_up(28'hFFF_FFFF);
    put_byte(10'd508, 8'hF7, 1'b1, 21'h1F_FFFF);
    look_up(28'hFFF_FFFF);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       begin kind_p = KIND_FAT12; res_p = 16'd0;             end
        1:       begin kind_p = KIND_FAT16; res_p = 16'hFFFF;          end
        2:       begin kind_p = KIND_FAT32; res_p = 16'($urandom);     end
        3:       begin kind_p = KIND_SPARE; res_p = 16'd1;             end
        4:       begin kind_p = KIND_FAT12; res_p = 16'($urandom);     end
        5:       begin kind_p = KIND_FAT16; res_p = 16'($urandom);     end
        default: begin kind_p = KIND_FAT32; res_p = 16'hFFFF;          end
      endcase
      set_reg(CFG_FAT_KIND, 16'(kind_p));
      set_reg(CFG_RESERVED, res_p);
      while (sent < DIRECTED + (p + 1) * PER_PHASE)
        session();
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    $display("%0d words: %0d hits (%0d end of chain), %0d misses, %0d fills",
             sent, hit_count, eoc_count, miss_count, fill_count);
    $display("FAT12, FAT16, FAT32 and spare type code; reserved sectors 0, 1, max, random");
    if (failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
